FILE: hw/rtl/quoted_token_splitter_macros.svh
// Assertion macros for the quoted token splitter
`ifndef QUOTED_TOKEN_SPLITTER_MACROS_SVH
`define QUOTED_TOKEN_SPLITTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define QTS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quoted_token_splitter: same-cycle check failed");

// next-cycle implication, checked outside reset
`define QTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quoted_token_splitter: next-cycle check failed");

`endif

FILE: hw/rtl/qts_pkg.sv
// Package: types, character codes and helpers for the quoted token splitter
`timescale 1ns / 1ps

package qts_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       token_end;
    logic       last_of_run;
  } result_t;

  function automatic logic is_oper(input logic [7:0] c);
    is_oper = (c == CH_SEMI) || (c == CH_EQ) || (c == CH_LPAR) || (c == CH_RPAR) ||
              (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

endpackage

FILE: hw/rtl/quoted_token_splitter.sv
// Top level: byte-stream tokenizer with quoted strings and a result queue
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_ch
//   out_     output     out_valid / out_stall out_char, out_char_valid,
//                                             out_token_end, out_last_of_run
//
// One byte per cycle while in_stall is low: a byte is held in the input register, then its
// zero to two results are written together into a four-entry result queue.
// The input side stalls only while the queue holds more than two results.
// Synchronous active-low reset clears string and token state and empties the queue.
// Output stalls back up through the queue to in_stall; nothing is dropped.
`timescale 1ns / 1ps
`include "quoted_token_splitter_macros.svh"

module quoted_token_splitter
  import qts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_token_end,
  output logic       out_last_of_run
);

  logic            vld_r;
  logic [7:0]      ch_r;
  logic            inq_r, inq_nxt;
  logic            dbl_r, dbl_nxt;
  logic            tok_r, tok_nxt;
  result_t         q_r [QDEPTH];
  logic [QAW-1:0]  wp_r, rp_r;
  logic [QCW-1:0]  cnt_r, cnt_nxt;

  logic            proc, pop, in_acc;
  logic            is_quote, is_dq, close_q, term, space, oper;
  logic [1:0]      push_n;
  result_t         r0, r1;

  assign proc     = vld_r && (cnt_r <= QCW'(QDEPTH - 2));
  assign in_stall = vld_r && !proc;
  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    is_quote = (ch_r == CH_SQUOT) || (ch_r == CH_DQUOT);
    is_dq    = (ch_r == CH_DQUOT);
    term     = (ch_r == CH_NUL) || (ch_r == CH_NL);
    space    = (ch_r == CH_SPACE);
    oper     = is_oper(ch_r);
    close_q  = 1'b0;
    inq_nxt  = inq_r;
    dbl_nxt  = dbl_r;
    tok_nxt  = tok_r;
    push_n   = 2'd0;
    r0       = '{out_char: ch_r, char_valid: 1'b1, token_end: 1'b0, last_of_run: 1'b1};
    r1       = '{out_char: ch_r, char_valid: 1'b1, token_end: 1'b1, last_of_run: 1'b1};
    if (is_quote) begin
      if (!inq_r) begin
        inq_nxt = 1'b1;
        dbl_nxt = is_dq;
      end else if (dbl_r == is_dq) begin
        close_q = 1'b1;
        inq_nxt = 1'b0;
        dbl_nxt = 1'b0;
      end
    end
    priority if (close_q) begin
      push_n  = {1'b0, tok_r};
      r0      = '{out_char: ch_r, char_valid: 1'b1, token_end: 1'b1, last_of_run: 1'b1};
      tok_nxt = 1'b0;
    end else if (term || (!inq_nxt && space)) begin
      push_n  = {1'b0, tok_r};
      r0      = '{out_char: CH_NUL, char_valid: 1'b0, token_end: 1'b1, last_of_run: 1'b1};
      tok_nxt = 1'b0;
    end else if (!inq_nxt && oper) begin
      if (tok_r) begin
        push_n = 2'd2;
        r0     = '{out_char: CH_NUL, char_valid: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
      end else begin
        push_n = 2'd1;
        r0     = r1;
      end
      tok_nxt = 1'b0;
    end else begin
      push_n  = 2'd1;
      tok_nxt = 1'b1;
    end
    if (!proc) begin
      push_n = 2'd0;
    end
    cnt_nxt = cnt_r + QCW'(push_n) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      inq_r <= 1'b0;
      dbl_r <= 1'b0;
      tok_r <= 1'b0;
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_acc) begin
        vld_r <= 1'b1;
      end else if (proc) begin
        vld_r <= 1'b0;
      end
      if (proc) begin
        inq_r <= inq_nxt;
        dbl_r <= dbl_nxt;
        tok_r <= tok_nxt;
      end
      wp_r  <= wp_r + QAW'(push_n);
      rp_r  <= rp_r + QAW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r <= in_ch;
    end
    if (push_n != 2'd0) begin
      q_r[wp_r] <= r0;
    end
    if (push_n == 2'd2) begin
      q_r[wp_r + QAW'(1)] <= r1;
    end
  end

  assign out_valid       = (cnt_r != '0);
  assign out_char        = q_r[rp_r].out_char;
  assign out_char_valid  = q_r[rp_r].char_valid;
  assign out_token_end   = q_r[rp_r].token_end;
  assign out_last_of_run = q_r[rp_r].last_of_run;

  `QTS_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_r <= QCW'(QDEPTH))
  `QTS_ASSERT_IMPLY(a_noval_zero, out_valid && !out_char_valid, out_char == CH_NUL)
  `QTS_ASSERT_NEXT(a_two_push, proc && (push_n == 2'd2) && !pop, cnt_r == $past(cnt_r) + QCW'(2))
  `QTS_ASSERT_NEXT(a_quote_hold, inq_r && !(proc && is_quote), inq_r)

endmodule

FILE: test/tb_top.sv
// Testbench for quoted_token_splitter: byte-stream tokens checked against a built-in predictor
`timescale 1ns / 1ps

module tb_top;
  import qts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_token_end;
  logic       out_last_of_run;

  result_t token_results_due[$];
  result_t want;
  bit      in_string = 1'b0;
  bit      string_is_double = 1'b0;
  bit      token_pending = 1'b0;
  bit      calm = 1'b0;
  int      errors = 0;
  int      bytes_accepted = 0;
  int      results_checked = 0;
  int      cycle_count = 0;

  quoted_token_splitter i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_char_valid  (out_char_valid),
    .out_token_end   (out_token_end),
    .out_last_of_run (out_last_of_run)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  function automatic bit is_op_char(input logic [7:0] c);
    case (c)
      CH_SEMI, CH_EQ, CH_LPAR, CH_RPAR, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t token_result(input logic [7:0] c, input logic v,
                                           input logic e, input logic l);
    result_t r;
    r.out_char    = v ? c : 8'h00;
    r.char_valid  = v;
    r.token_end   = e;
    r.last_of_run = l;
    return r;
  endfunction

  function automatic void split_byte(input logic [7:0] c);
    bit closing;
    closing = 1'b0;
    if (c == CH_SQUOT || c == CH_DQUOT) begin
      if (!in_string) begin
        in_string = 1'b1;
        string_is_double = (c == CH_DQUOT);
      end else if (string_is_double == (c == CH_DQUOT)) begin
        closing = 1'b1;
        in_string = 1'b0;
        string_is_double = 1'b0;
      end
    end
    if (closing) begin
      if (token_pending) begin
        token_results_due.insert(token_results_due.size(),
                                 token_result(c, 1'b1, 1'b1, 1'b1));
        token_pending = 1'b0;
      end
    end else if (c == CH_NUL || c == CH_NL || (!in_string && c == CH_SPACE)) begin
      if (token_pending) begin
        token_results_due.insert(token_results_due.size(),
                                 token_result(8'h00, 1'b0, 1'b1, 1'b1));
        token_pending = 1'b0;
      end
    end else if (!in_string && is_op_char(c)) begin
      if (token_pending) begin
        token_results_due.insert(token_results_due.size(),
                                 token_result(8'h00, 1'b0, 1'b1, 1'b0));
        token_pending = 1'b0;
      end
      token_results_due.insert(token_results_due.size(),
                               token_result(c, 1'b1, 1'b1, 1'b1));
    end else begin
      token_results_due.insert(token_results_due.size(),
                               token_result(c, 1'b1, 1'b0, 1'b1));
      token_pending = 1'b1;
    end
  endfunction

  function automatic logic [7:0] pick_op_char();
    case ($urandom_range(0, 7))
      0: return CH_SEMI;
      1: return CH_EQ;
      2: return CH_LPAR;
      3: return CH_RPAR;
      4: return CH_PLUS;
      5: return CH_MINUS;
      6: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_word_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(8'h21, 8'h7E));
    end while (is_op_char(c) || c == CH_SQUOT || c == CH_DQUOT);
    return c;
  endfunction

  function automatic logic [7:0] pick_string_char(input logic [7:0] quote);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 5) return CH_SPACE;
    if (roll < 9) return pick_op_char();
    if (roll == 9) return (quote == CH_DQUOT) ? CH_SQUOT : CH_DQUOT;
    if (roll == 10) return CH_NL;
    if (roll == 11) return 8'($urandom_range(8'h80, 8'hFF));
    return pick_word_char();
  endfunction

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("tb_top: mismatch on %s: expected %0h, got %0h (result %0d)",
             what, exp_val, got_val, results_checked);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    split_byte(c);
    bytes_accepted++;
  endtask

  task automatic wait_for_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (token_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_phrase();
    int         kind;
    int         len;
    logic [7:0] q;
    kind = $urandom_range(0, 15);
    if (kind < 6) begin
      len = $urandom_range(1, 6);
      repeat (len) send_byte(pick_word_char());
    end else if (kind < 8) begin
      send_byte(pick_op_char());
    end else if (kind < 11) begin
      q = $urandom_range(0, 1) ? CH_DQUOT : CH_SQUOT;
      send_byte(q);
      len = $urandom_range(0, 8);
      repeat (len) send_byte(pick_string_char(q));
      if ($urandom_range(0, 7) != 0) send_byte(q);
    end else if (kind < 14) begin
      send_byte(($urandom_range(0, 3) == 0) ? CH_NL : CH_SPACE);
    end else if (kind == 14) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(CH_NUL);
    end
  endtask

  task automatic test_directed();
    logic [7:0] script [25];
    script = '{8'h61, 8'hFF, CH_SPACE, CH_SPACE, CH_PLUS, 8'h78, CH_SEMI, CH_EQ,
               CH_LPAR, CH_RPAR, CH_MINUS, CH_STAR, CH_SLASH, CH_DQUOT, 8'h61,
               CH_SQUOT, CH_SPACE, CH_LPAR, CH_NL, CH_DQUOT, 8'h62, CH_SQUOT,
               CH_NUL, 8'h80, CH_SQUOT};
    foreach (script[i]) send_byte(script[i]);
    send_byte(CH_NUL);
  endtask

  task automatic test_random_text(input int count);
    int target;
    target = bytes_accepted + count;
    while (bytes_accepted < target) send_phrase();
  endtask

  task automatic test_drain_pause();
    repeat (6) send_phrase();
    wait_for_tokens();
    repeat (6) send_phrase();
  endtask

  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    test_random_text(count);
    calm = 1'b0;
  endtask

  initial begin
    int hold;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (token_results_due.size() == 0) begin
        report_mismatch("result with nothing pending", 0, int'(out_char));
      end else begin
        want = token_results_due.pop_front();
        if (out_char !== want.out_char)
          report_mismatch("out_char", int'(want.out_char), int'(out_char));
        if (out_char_valid !== want.char_valid)
          report_mismatch("out_char_valid", int'(want.char_valid), int'(out_char_valid));
        if (out_token_end !== want.token_end)
          report_mismatch("out_token_end", int'(want.token_end), int'(out_token_end));
        if (out_last_of_run !== want.last_of_run)
          report_mismatch("out_last_of_run", int'(want.last_of_run),
                          int'(out_last_of_run));
      end
      results_checked++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_for_tokens();
    test_random_text(600);
    test_drain_pause();
    test_back_to_back(250);
    test_random_text(450);
    wait_for_tokens();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/qts_pkg.sv
hw/rtl/quoted_token_splitter.sv
test/tb_top.sv
